// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)

`endif

`endif

// ===== rtl/bcdas_pkg.sv =====
// ----------------------------------------------------------------------------
// BCD add/subtract/compare package
// Shared constants, operation codes, the pipeline item type and the
// per-digit decimal add and subtract functions.
// ----------------------------------------------------------------------------
package bcdas_pkg;

    // Operand geometry.
    localparam int MAX_DIGITS       = 16;
    localparam int DIGITS_DEFAULT   = 16;
    localparam int OPERAND_W        = 64;
    localparam int DIGITS_PER_STAGE = 4;
    localparam int SLICE_STAGES     = MAX_DIGITS / DIGITS_PER_STAGE;

    // Stream widths.
    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    // Operation codes carried in s_tuser.
    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_CMP = 2'd2;

    // Compare result codes.
    localparam logic [1:0] ORDER_EQ = 2'd0;
    localparam logic [1:0] ORDER_LT = 2'd1;
    localparam logic [1:0] ORDER_GT = 2'd2;

    // One operation as it travels down the pipeline.
    typedef struct packed {
        logic [1:0]           func;
        logic [OPERAND_W-1:0] a;
        logic [OPERAND_W-1:0] b;
        logic [OPERAND_W-1:0] value;
        logic [1:0]           carry;   // add carry 0..3, or borrow in bit 0
        logic                 clamp;
        logic [1:0]           order;
    } bcdas_item_t;

    // Decimal add of one digit: returns {carry_out[1:0], digit[3:0]}.
    // Non-decimal nibbles can push the digit sum up to 33, so the carry
    // can reach three.
    function automatic logic [5:0] bcd_add_digit(input logic [3:0] da,
                                                 input logic [3:0] db,
                                                 input logic [1:0] cin);
        logic [5:0] sum;
        logic [1:0] cout;
        logic [5:0] digit;
        sum = {2'b00, da} + {2'b00, db} + {4'b0000, cin};
        if (sum >= 6'd30) begin
            cout  = 2'd3;
            digit = sum - 6'd30;
        end else if (sum >= 6'd20) begin
            cout  = 2'd2;
            digit = sum - 6'd20;
        end else if (sum >= 6'd10) begin
            cout  = 2'd1;
            digit = sum - 6'd10;
        end else begin
            cout  = 2'd0;
            digit = sum;
        end
        return {cout, digit[3:0]};
    endfunction

    // Decimal subtract of one digit: returns {borrow_out, digit[3:0]}.
    function automatic logic [4:0] bcd_sub_digit(input logic [3:0] da,
                                                 input logic [3:0] db,
                                                 input logic       bin);
        logic [4:0] sub_amt;
        logic       no_borrow;
        logic [4:0] diff;
        sub_amt   = {1'b0, db} + {4'b0000, bin};
        no_borrow = ({1'b0, da} >= sub_amt);
        diff      = {1'b0, da} + (no_borrow ? 5'd0 : 5'd10) - sub_amt;
        return {!no_borrow, diff[3:0]};
    endfunction

endpackage

// ===== rtl/bcd_add_sub_compare.sv =====
// ----------------------------------------------------------------------------
// BCD add/subtract/compare unit
// Packed-BCD arithmetic on two operands of up to sixteen digits: decimal add
// with carry out, subtract clamped at zero, and magnitude compare.
//
//   channel  direction  tdata                              tuser
//   s_       in         operand_a, operand_b               func
//   m_       out        result_value, carry_out, clamped,  -
//                       order
//
// One transaction is accepted per clock unless m_tready stalls a full
// pipeline; there is no kept state between them. The stages are the input
// register, four carry-ripple slices of four digits and the output register.
// Reset clears only the stage valid bits.
// A stall on m_tready holds every full stage; an empty stage still fills, so
// s_tready drops only when all six stages hold a transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcd_add_sub_compare #(
    parameter int DIGITS = bcdas_pkg::DIGITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] operand_a, [127:64] operand_b
    input  logic [bcdas_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  logic [bcdas_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] result_value, [64] carry_out, [65] clamped, [67:66] order,
    // [71:68] zero
    output logic [bcdas_pkg::M_TDATA_W-1:0] m_tdata
);
    import bcdas_pkg::*;

    logic        stage_valid [0:SLICE_STAGES];
    logic        stage_ready [0:SLICE_STAGES];
    bcdas_item_t stage_item  [0:SLICE_STAGES];

    logic                 out_valid_reg;
    logic [OPERAND_W-1:0] value_reg;
    logic                 carry_reg;
    logic                 clamped_reg;
    logic [1:0]           order_reg;
    logic [OPERAND_W-1:0] value_next;
    logic                 carry_next;
    logic                 clamped_next;
    logic [1:0]           order_next;
    logic                 out_load;
    bcdas_item_t          last_item;

    // Input register and compare.
    bcdas_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_a      (s_tdata[OPERAND_W-1:0]),
        .in_b      (s_tdata[2*OPERAND_W-1:OPERAND_W]),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_item  (stage_item[0])
    );

    // Carry ripple, four digits per stage.
    for (genvar g = 0; g < SLICE_STAGES; g++) begin : g_slice
        bcdas_digit_stage #(
            .DIGITS      (DIGITS),
            .STAGE_INDEX (g)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_item   (stage_item[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_item  (stage_item[g+1])
        );
    end

    // Final result formatting: each field only for its own operation.
    assign last_item = stage_item[SLICE_STAGES];

    always_comb begin
        value_next   = '0;
        carry_next   = 1'b0;
        clamped_next = 1'b0;
        order_next   = ORDER_EQ;
        case (last_item.func)
            FUNC_ADD: begin
                value_next = last_item.value;
                carry_next = (last_item.carry != 2'd0);
            end
            FUNC_SUB: begin
                clamped_next = last_item.clamp;
                value_next   = last_item.clamp ? '0 : last_item.value;
            end
            FUNC_CMP: begin
                order_next = last_item.order;
            end
            default: begin
                value_next = '0;
            end
        endcase
    end

    // Output register.
    assign out_load                  = !out_valid_reg || m_tready;
    assign stage_ready[SLICE_STAGES] = out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= stage_valid[SLICE_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && stage_valid[SLICE_STAGES]) begin
            value_reg   <= value_next;
            carry_reg   <= carry_next;
            clamped_reg <= clamped_next;
            order_reg   <= order_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, order_reg, clamped_reg, carry_reg, value_reg};

    // A carry and a clamp come from different operations.
    `ASSERT_NEVER(a_carry_clamp_excl, aclk, aresetn, m_tvalid && m_tdata[64] && m_tdata[65],
        "carry_out and clamped both set")

    // A clamped or compare result carries a zero value.
    `ASSERT_CLK(a_zero_value, aclk, aresetn,
        m_tvalid && (m_tdata[65] || (m_tdata[67:66] != ORDER_EQ)) |-> m_tdata[63:0] == '0,
        "nonzero value with clamp or order")

    // Back-pressure reaches the input only with the whole pipeline full.
    `ASSERT_CLK(a_full_on_stall, aclk, aresetn, !s_tready |-> (m_tvalid && !m_tready),
        "input stalled while output can drain")

endmodule

// ===== rtl/bcdas_front.sv =====
// ----------------------------------------------------------------------------
// BCD unit input stage
// Registers the incoming transaction, masks the operands to the active digit
// count and resolves the magnitude compare used by compare and subtract.
// ----------------------------------------------------------------------------
module bcdas_front #(
    parameter int DIGITS = bcdas_pkg::DIGITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bcdas_pkg::S_TUSER_W-1:0] in_func,
    input  logic [bcdas_pkg::OPERAND_W-1:0] in_a,
    input  logic [bcdas_pkg::OPERAND_W-1:0] in_b,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bcdas_pkg::bcdas_item_t         out_item
);
    import bcdas_pkg::*;

    localparam int ACTIVE_BITS = DIGITS * 4;
    localparam logic [OPERAND_W-1:0] OPERAND_MASK =
        {OPERAND_W{1'b1}} >> (OPERAND_W - ACTIVE_BITS);

    logic                 valid_reg;
    bcdas_item_t          item_reg;
    bcdas_item_t          item_next;
    logic [OPERAND_W-1:0] a_masked;
    logic [OPERAND_W-1:0] b_masked;
    logic                 a_lt_b;
    logic                 a_eq_b;

    // Mask operands and compare them; nibble order equals binary order.
    always_comb begin
        a_masked = in_a & OPERAND_MASK;
        b_masked = in_b & OPERAND_MASK;
        a_lt_b   = (a_masked < b_masked);
        a_eq_b   = (a_masked == b_masked);

        item_next       = '0;
        item_next.func  = in_func;
        item_next.a     = a_masked;
        item_next.b     = b_masked;
        item_next.clamp = (in_func == FUNC_SUB) && a_lt_b;
        if (in_func == FUNC_CMP) begin
            item_next.order = a_lt_b ? ORDER_LT : (a_eq_b ? ORDER_EQ : ORDER_GT);
        end else begin
            item_next.order = ORDER_EQ;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Stage register: loads whenever the stage is empty or draining.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/bcdas_digit_stage.sv =====
// ----------------------------------------------------------------------------
// BCD unit digit slice stage
// Ripples the decimal carry or borrow through one slice of four digits and
// registers the partial result with the carry for the next slice.
// ----------------------------------------------------------------------------
module bcdas_digit_stage #(
    parameter int DIGITS      = bcdas_pkg::DIGITS_DEFAULT,
    parameter int STAGE_INDEX = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  bcdas_pkg::bcdas_item_t in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output bcdas_pkg::bcdas_item_t out_item
);
    import bcdas_pkg::*;

    logic        valid_reg;
    bcdas_item_t item_reg;
    bcdas_item_t item_next;
    logic [1:0]  carry;
    logic [5:0]  add_res;
    logic [4:0]  sub_res;

    // Four dependent digit steps; digits above DIGITS pass the carry along.
    always_comb begin
        item_next = in_item;
        carry     = in_item.carry;
        add_res   = '0;
        sub_res   = '0;
        for (int j = 0; j < DIGITS_PER_STAGE; j++) begin
            if (STAGE_INDEX * DIGITS_PER_STAGE + j < DIGITS) begin
                case (in_item.func)
                    FUNC_ADD: begin
                        add_res = bcd_add_digit(
                            in_item.a[4*(STAGE_INDEX*DIGITS_PER_STAGE+j) +: 4],
                            in_item.b[4*(STAGE_INDEX*DIGITS_PER_STAGE+j) +: 4],
                            carry);
                        item_next.value[4*(STAGE_INDEX*DIGITS_PER_STAGE+j) +: 4] =
                            add_res[3:0];
                        carry = add_res[5:4];
                    end
                    FUNC_SUB: begin
                        sub_res = bcd_sub_digit(
                            in_item.a[4*(STAGE_INDEX*DIGITS_PER_STAGE+j) +: 4],
                            in_item.b[4*(STAGE_INDEX*DIGITS_PER_STAGE+j) +: 4],
                            carry[0]);
                        item_next.value[4*(STAGE_INDEX*DIGITS_PER_STAGE+j) +: 4] =
                            sub_res[3:0];
                        carry = {1'b0, sub_res[4]};
                    end
                    default: begin
                        carry = carry;
                    end
                endcase
            end
        end
        item_next.carry = carry;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Stage register with its valid bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule
